FILE: rtl/core/ttss_pkg.sv
// Shared types, constants and segment table for the two-digit serializer.
package ttss_pkg;

  localparam int NumCells  = 32;
  localparam int FrameBits = 16;

  localparam logic [7:0] SelTens  = 8'hFD;
  localparam logic [7:0] SelOnes  = 8'hFE;
  localparam logic [7:0] SelBlank = 8'h03;
  localparam logic [7:0] SegBlank = 8'h00;
  localparam logic [6:0] MaxValue = 7'd99;

  typedef struct packed {
    logic [6:0] value;
    logic       blank;
  } in_t;

  typedef struct packed {
    logic serial_bit;
    logic latch_after;
    logic last;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } cell_t;

  // Common-cathode segment patterns for digits 0..9.
  function automatic logic [7:0] seg_lut(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0:    seg = 8'h7E;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'hBC;
      4'd3:    seg = 8'hAE;
      4'd4:    seg = 8'hC6;
      4'd5:    seg = 8'hEA;
      4'd6:    seg = 8'hDA;
      4'd7:    seg = 8'h26;
      4'd8:    seg = 8'hFE;
      4'd9:    seg = 8'hE6;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

endpackage

FILE: rtl/core/two_digit_seven_segment_serializer.sv
// Top level: serializes a two-digit display request into shift-register bits.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one request:
//   a value 0..99 (larger values show 99) or a blank flag.
//   Output channel (out_valid_o / out_ready_i / out_data_o) gives one
//   serial bit per transfer, MSB first, with latch_after on the 16th bit of
//   each frame and last on the final bit of the request.
//   A value yields 32 bits (tens frame, then ones frame); blank yields 16.
//   The first bit is offered the cycle after the request is accepted.
//   Throughput is one bit per cycle while the receiver takes every bit,
//   set by the 32-stage output chain that shifts one cell per transfer.
//   The next request is accepted in the same cycle the final bit of the
//   current one is taken, so runs follow each other with no gap.
//   When the receiver stalls the chain holds, and so does in_ready_o.
//   Reset empties the chain; the block is ready right after reset.
module two_digit_seven_segment_serializer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ttss_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ttss_pkg::out_t   out_data_o
);
  import ttss_pkg::*;

  cell_t load_data [NumCells];
  cell_t cells     [NumCells];
  logic  shift;
  logic  load;

  ttss_frame_gen u_frame_gen (
    .req_i  (in_data_i),
    .load_o (load_data)
  );

  // Advance whenever the head is empty or being taken.
  assign shift      = !cells[0].valid || out_ready_i;
  assign in_ready_o = !cells[1].valid && shift;
  assign load       = in_valid_i && in_ready_o;

  for (genvar i = 0; i < NumCells; i++) begin : g_chain
    cell_t next;
    if (i == NumCells - 1) begin : g_tail
      assign next = '0;
    end else begin : g_mid
      assign next = cells[i+1];
    end

    ttss_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift),
      .load_i      (load),
      .load_data_i (load_data[i]),
      .next_i      (next),
      .q_o         (cells[i])
    );
  end

  assign out_valid_o = cells[0].valid;
  assign out_data_o  = cells[0].data;

endmodule

FILE: rtl/core/ttss_cell.sv
// One stage of the output chain: holds one serial bit and its frame marks.
module ttss_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  logic           load_i,
  input  ttss_pkg::cell_t load_data_i,
  input  ttss_pkg::cell_t next_i,
  output ttss_pkg::cell_t q_o
);
  import ttss_pkg::*;

  cell_t cell_d, cell_q;

  always_comb begin
    cell_d = cell_q;
    if (load_i) begin
      cell_d = load_data_i;
    end else if (shift_i) begin
      cell_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

FILE: rtl/core/ttss_frame_gen.sv
// Splits a request into digits and builds the bit pattern loaded into the chain.
module ttss_frame_gen (
  input  ttss_pkg::in_t   req_i,
  output ttss_pkg::cell_t load_o [ttss_pkg::NumCells]
);
  import ttss_pkg::*;

  logic [6:0]  v_sat;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  diff;
  logic [3:0]  ones;
  logic [15:0] word0;
  logic [15:0] word1;

  // Divide by ten via reciprocal multiply; exact for values up to 99.
  assign v_sat    = (req_i.value > MaxValue) ? MaxValue : req_i.value;
  assign prod     = {8'd0, v_sat} * 15'd205;
  assign tens     = prod[14:11];
  assign tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
  assign diff     = v_sat - tens_x10;
  assign ones     = diff[3:0];

  assign word0 = req_i.blank ? {SelBlank, SegBlank} : {SelTens, seg_lut(tens)};
  assign word1 = {SelOnes, seg_lut(ones)};

  for (genvar i = 0; i < NumCells; i++) begin : g_bits
    localparam int Pos = i % FrameBits;
    if (i < FrameBits) begin : g_first
      assign load_o[i].valid            = 1'b1;
      assign load_o[i].data.serial_bit  = word0[FrameBits-1-Pos];
      assign load_o[i].data.latch_after = (Pos == FrameBits - 1);
      assign load_o[i].data.last        = req_i.blank && (Pos == FrameBits - 1);
    end else begin : g_second
      assign load_o[i].valid            = !req_i.blank;
      assign load_o[i].data.serial_bit  = word1[FrameBits-1-Pos];
      assign load_o[i].data.latch_after = (Pos == FrameBits - 1);
      assign load_o[i].data.last        = (i == NumCells - 1);
    end
  end

endmodule

FILE: tb/tb_two_digit_seven_segment_serializer.sv
// Testbench for the two-digit serializer: queued requests, predicted bit stream, field checks.
module tb_two_digit_seven_segment_serializer;
  timeunit 1ns;
  timeprecision 1ps;

  import ttss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 40;

  // Common-cathode patterns, digits 0..9.
  localparam logic [7:0] DIGIT_SEG [10] = '{
    8'h7E, 8'h06, 8'hBC, 8'hAE, 8'hC6, 8'hEA, 8'hDA, 8'h26, 8'hFE, 8'hE6
  };

  typedef struct packed {
    out_t        bits;
    int unsigned tag;  // cycle in which the owning request was accepted
  } exp_bit_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  in_t         request_q [$];
  exp_bit_t    serial_bit_q [$];
  int unsigned cycle_cnt     = 0;
  int unsigned err_cnt       = 0;
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 71;

  two_digit_seven_segment_serializer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Queue one 16-bit frame, select byte first, MSB first.
  task automatic push_frame(input logic [7:0] sel, input logic [7:0] seg,
                            input logic final_frame, input int unsigned tag);
    logic [15:0] word;
    exp_bit_t    e;
    word = {sel, seg};
    for (int i = 15; i >= 0; i--) begin
      e.bits.serial_bit  = word[i];
      e.bits.latch_after = (i == 0);
      e.bits.last        = (i == 0) && final_frame;
      e.tag              = tag;
      serial_bit_q.push_back(e);
    end
  endtask

  task automatic predict_serial_bits(input in_t req, input int unsigned tag);
    logic [6:0] shown;
    int         tens;
    int         ones;
    if (req.blank) begin
      push_frame(SelBlank, SegBlank, 1'b1, tag);
    end else begin
      // Saturate out-of-range values to 99.
      shown = (req.value > MaxValue) ? MaxValue : req.value;
      tens  = shown / 10;
      ones  = shown % 10;
      push_frame(SelTens, DIGIT_SEG[tens], 1'b0, tag);
      push_frame(SelOnes, DIGIT_SEG[ones], 1'b1, tag);
    end
  endtask

  function automatic in_t make_request(input logic [6:0] value, input logic blank);
    in_t r;
    r.value = value;
    r.blank = blank;
    return r;
  endfunction

  function automatic in_t random_request();
    in_t         r;
    int unsigned pick;
    pick    = $urandom_range(99);
    r.value = 7'($urandom_range(99));
    r.blank = 1'b0;
    if (pick < 12) begin
      r.blank = 1'b1;
      r.value = 7'($urandom_range(127));
    end else if (pick < 24) begin
      r.value = 7'($urandom_range(127, 100));
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic exp_v, input logic got_v);
    if (got_v !== exp_v) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %b, actual %b", $time, name, exp_v, got_v);
    end
  endtask

  task automatic drain_all();
    while (request_q.size() != 0 || in_valid_i || serial_bit_q.size() != 0)
      @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Request driver: hold valid and payload until accepted.
  always @(posedge clk_i) begin : driver
    logic held;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      held = in_valid_i && !in_ready_o;
      if (in_valid_i && in_ready_o)
        predict_serial_bits(in_data_i, cycle_cnt);
      if (!held) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= request_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Bit monitor and receiver stall.
  always @(posedge clk_i) begin : monitor
    exp_bit_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        // A bit cannot belong to a request accepted at this very edge.
        if (serial_bit_q.size() == 0 || serial_bit_q[0].tag == cycle_cnt) begin
          err_cnt++;
          $display("%0t: unexpected bit: expected none, actual %b", $time, out_data_o);
        end else begin
          e = serial_bit_q.pop_front();
          check_field("serial_bit", e.bits.serial_bit, out_data_o.serial_bit);
          check_field("latch_after", e.bits.latch_after, out_data_o.latch_after);
          check_field("last", e.bits.last, out_data_o.last);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every digit in both places, range ends, saturation and blanks.
    for (int d = 0; d < 10; d++)
      request_q.push_back(make_request(7'(d * 11), 1'b0));
    request_q.push_back(make_request(7'd100, 1'b0));
    request_q.push_back(make_request(7'd127, 1'b0));
    request_q.push_back(make_request(7'd9, 1'b0));
    request_q.push_back(make_request(7'd90, 1'b0));
    request_q.push_back(make_request(7'd0, 1'b1));
    request_q.push_back(make_request(7'd127, 1'b1));
    request_q.push_back(make_request(7'd42, 1'b1));
    request_q.push_back(make_request(7'd1, 1'b0));
    for (int n = 0; n < 95; n++)
      request_q.push_back(random_request());
    drain_all();

    send_idle_pct <= 71;
    recv_idle_pct <= 31;
    for (int n = 0; n < 100; n++)
      request_q.push_back(random_request());
    drain_all();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    for (int n = 0; n < 100; n++)
      request_q.push_back(random_request());
    drain_all();

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
